FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL file cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// Types, constants and helpers of the cubic Bezier flattener
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

	localparam int CBF_COORD_BITS = 32;
	localparam int CBF_MAX_DEPTH  = 4;
	localparam int CBF_DEPTH_BITS = 3;

	typedef logic signed [CBF_COORD_BITS-1:0] coord_t;

	localparam coord_t CBF_COORD_MAX = {1'b0, {(CBF_COORD_BITS-1){1'b1}}};
	localparam coord_t CBF_COORD_MIN = {1'b1, {(CBF_COORD_BITS-1){1'b0}}};

	localparam logic [1:0] FUNC_CUBIC = 2'd0;
	localparam logic [1:0] FUNC_QUAD  = 2'd1;
	localparam logic [1:0] FUNC_MOVE  = 2'd2;
	localparam logic [1:0] FUNC_RESET = 2'd3;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef pt_t [3:0] cubic_t;

	typedef struct packed {
		logic [1:0] func;
		coord_t     ctrl1_x;
		coord_t     ctrl1_y;
		coord_t     ctrl2_x;
		coord_t     ctrl2_y;
		coord_t     end_x;
		coord_t     end_y;
	} cbf_in_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_max_x;
		coord_t box_max_y;
		logic   last_point;
	} cbf_out_t;

	// floor((a + b) / 2)
	function automatic coord_t cbf_mid(input coord_t a, input coord_t b);
		logic [CBF_COORD_BITS:0] s;
		s = {a[CBF_COORD_BITS-1], a} + {b[CBF_COORD_BITS-1], b};
		return s[CBF_COORD_BITS:1];
	endfunction

	function automatic pt_t cbf_mid_pt(input pt_t a, input pt_t b);
		pt_t r;
		r.x = cbf_mid(a.x, b.x);
		r.y = cbf_mid(a.y, b.y);
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Path command flattener: cubic and quadratic curves to polyline vertices
// ----------------------------------------------------------------------------
// Usage:
//  in channel (in_valid/in_ready/in_data) takes one path command at a time;
//  in_ready is high only while the block is idle.
//  out channel (out_valid/out_ready/out_data) gives the vertices of that
//  command, the final one marked by last_point.
//  cfg_we/cfg_wdata write subdivision_depth; the user must write it only while
//  idle, as the block itself has no check for this. A move gives its one vertex.
//  A curve of depth d runs through (2^d - 1) splits, each computing the first
//  and second midpoints and then pushing the right half, and 2^d leaves, each
//  a check and then its three vertices; opening a subpath first forces a vertex.
//  A quadratic first runs the bit-serial divide by three of its 2/3 weights.
//  One vertex is checked per cycle unless the receiver stalls; its output is
//  held back by one kept vertex so that last_point can be set.
//  If the receiver stalls, the block waits with its state intact.
//  Reset clears pen, box and subpath flags, and sets depth to MAX_DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cubic_bezier_flattener
	import cbf_pkg::*;
#(
	parameter int MAX_DEPTH = CBF_MAX_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CBF_DEPTH_BITS-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire cbf_in_t                   in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output cbf_out_t                       out_data
);

	localparam int CB  = CBF_COORD_BITS;
	localparam int UW  = CB + 3;
	localparam int DCW = $clog2(UW + 1);
	localparam int STK = (MAX_DEPTH > 0) ? MAX_DEPTH : 1;
	localparam int SPW = $clog2(STK + 1);
	localparam int IW  = (STK > 1) ? $clog2(STK) : 1;
	localparam int LW  = ($clog2(MAX_DEPTH + 1) > 0) ? $clog2(MAX_DEPTH + 1) : 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FORCE  = 3'd1;
	localparam logic [2:0] ST_DINIT  = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_SETUP  = 3'd4;
	localparam logic [2:0] ST_SPLIT  = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0]                state_q;
	logic [CBF_DEPTH_BITS-1:0] depth_q;
	cbf_in_t                   cmd_q;
	coord_t                    pen_x_q, pen_y_q;
	coord_t                    min_x_q, min_y_q, max_x_q, max_y_q;
	logic                      need_sub_q, has_pt_q;
	cbf_out_t                  pend_q, out_q;
	logic                      pend_v_q, out_v_q;
	cubic_t                    cur_q;
	logic [LW-1:0]             lvl_q;
	logic [1:0]                phase_q, idx_q;
	cubic_t                    stk_c_q [STK];
	logic [LW-1:0]             stk_l_q [STK];
	logic [SPW-1:0]            sp_q;
	pt_t                       ab_q, bc_q, cd_q, abc_q, bcd_q;
	logic [UW-1:0]             u_q [4];
	logic [1:0]                r_q [4];
	coord_t                    q_q [4];
	logic [DCW-1:0]            dcnt_q;

	logic          out_free, keep, go, force_v, in_acc, out_load;
	coord_t        vx, vy, nmin_x, nmin_y, nmax_x, nmax_y;
	pt_t           vpt, abcd;
	logic [LW-1:0] eff_depth;
	logic [IW-1:0] top;
	coord_t        d_base [4];
	coord_t        d_ctrl [4];
	logic [UW-1:0] d_u [4];

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign out_free  = !out_v_q || out_ready;
	assign top       = IW'(sp_q - SPW'(1));
	assign eff_depth = (depth_q > CBF_DEPTH_BITS'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(depth_q);
	assign abcd      = cbf_mid_pt(abc_q, bcd_q);
	assign out_load  = (((state_q == ST_FORCE || state_q == ST_EMIT) && go && keep) ||
		state_q == ST_FINISH) && pend_v_q && out_free;

	// vertex under test
	always_comb begin
		if (state_q == ST_FORCE) begin
			force_v = 1'b1;
			if (cmd_q.func == FUNC_MOVE) begin
				vpt.x = cmd_q.end_x;
				vpt.y = cmd_q.end_y;
			end else begin
				vpt.x = cmd_q.ctrl1_x;
				vpt.y = cmd_q.ctrl1_y;
			end
		end else begin
			force_v = 1'b0;
			vpt     = cur_q[2'(idx_q + 2'd1)];
		end
		vx     = vpt.x;
		vy     = vpt.y;
		keep   = force_v || !(has_pt_q && vx == pen_x_q && vy == pen_y_q);
		go     = !keep || !pend_v_q || out_free;
		nmin_x = (vx < min_x_q) ? vx : min_x_q;
		nmin_y = (vy < min_y_q) ? vy : min_y_q;
		nmax_x = (vx > max_x_q) ? vx : max_x_q;
		nmax_y = (vy > max_y_q) ? vy : max_y_q;
	end

	// divide lanes: base and control of each 2/3 weight
	always_comb begin
		logic [CB:0]   diff;
		logic [CB+1:0] n;
		d_base[0] = pen_x_q;      d_ctrl[0] = cmd_q.ctrl1_x;
		d_base[1] = pen_y_q;      d_ctrl[1] = cmd_q.ctrl1_y;
		d_base[2] = cmd_q.end_x;  d_ctrl[2] = cmd_q.ctrl1_x;
		d_base[3] = cmd_q.end_y;  d_ctrl[3] = cmd_q.ctrl1_y;
		for (int i = 0; i < 4; i++) begin
			diff   = {d_ctrl[i][CB-1], d_ctrl[i]} - {d_base[i][CB-1], d_base[i]};
			n      = {diff, 1'b0};
			d_u[i] = {n[CB+1], n} + {2'b11, {(CB+1){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			depth_q    <= CBF_DEPTH_BITS'(MAX_DEPTH);
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			min_x_q    <= CBF_COORD_MAX;
			min_y_q    <= CBF_COORD_MAX;
			max_x_q    <= CBF_COORD_MIN;
			max_y_q    <= CBF_COORD_MIN;
			need_sub_q <= 1'b1;
			has_pt_q   <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			sp_q       <= '0;
			lvl_q      <= '0;
			phase_q    <= '0;
			idx_q      <= '0;
			dcnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				depth_q <= cfg_wdata;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			if ((state_q == ST_FORCE || state_q == ST_EMIT) && go && keep) begin
				pen_x_q  <= vx;
				pen_y_q  <= vy;
				has_pt_q <= 1'b1;
				min_x_q  <= nmin_x;
				min_y_q  <= nmin_y;
				max_x_q  <= nmax_x;
				max_y_q  <= nmax_y;
				pend_v_q <= 1'b1;
				pend_q   <= '{vx, vy, nmin_x, nmin_y, nmax_x, nmax_y, 1'b0};
				if (pend_v_q) begin
					out_q <= pend_q;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cmd_q <= in_data;
						case (in_data.func)
							FUNC_RESET: begin
								pen_x_q    <= '0;
								pen_y_q    <= '0;
								min_x_q    <= CBF_COORD_MAX;
								min_y_q    <= CBF_COORD_MAX;
								max_x_q    <= CBF_COORD_MIN;
								max_y_q    <= CBF_COORD_MIN;
								need_sub_q <= 1'b1;
								has_pt_q   <= 1'b0;
							end
							FUNC_MOVE: state_q <= ST_FORCE;
							default: begin
								if (need_sub_q) begin
									state_q <= ST_FORCE;
								end else if (in_data.func == FUNC_QUAD) begin
									state_q <= ST_DINIT;
								end else begin
									state_q <= ST_SETUP;
								end
							end
						endcase
					end
				end
				ST_FORCE: begin
					if (go) begin
						need_sub_q <= 1'b0;
						case (cmd_q.func)
							FUNC_MOVE: state_q <= ST_FINISH;
							FUNC_QUAD: state_q <= ST_DINIT;
							default:   state_q <= ST_SETUP;
						endcase
					end
				end
				ST_DINIT: begin
					for (int i = 0; i < 4; i++) begin
						u_q[i] <= d_u[i];
						r_q[i] <= '0;
					end
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring divide by three, one quotient bit per cycle
					for (int i = 0; i < 4; i++) begin
						logic [2:0] r3;
						logic       ge;
						r3     = {r_q[i], u_q[i][UW-1]};
						ge     = (r3 >= 3'd3);
						r_q[i] <= ge ? 2'(r3 - 3'd3) : r3[1:0];
						q_q[i] <= {q_q[i][CB-2:0], ge};
						u_q[i] <= {u_q[i][UW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(UW - 1)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					cur_q[0] <= '{pen_x_q, pen_y_q};
					if (cmd_q.func == FUNC_QUAD) begin
						cur_q[1] <= '{pen_x_q + q_q[0], pen_y_q + q_q[1]};
						cur_q[2] <= '{cmd_q.end_x + q_q[2], cmd_q.end_y + q_q[3]};
					end else begin
						cur_q[1] <= '{cmd_q.ctrl1_x, cmd_q.ctrl1_y};
						cur_q[2] <= '{cmd_q.ctrl2_x, cmd_q.ctrl2_y};
					end
					cur_q[3] <= '{cmd_q.end_x, cmd_q.end_y};
					lvl_q    <= eff_depth;
					sp_q     <= '0;
					phase_q  <= '0;
					state_q  <= ST_SPLIT;
				end
				ST_SPLIT: begin
					if (lvl_q == '0) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						case (phase_q)
							2'd0: begin
								ab_q    <= cbf_mid_pt(cur_q[0], cur_q[1]);
								bc_q    <= cbf_mid_pt(cur_q[1], cur_q[2]);
								cd_q    <= cbf_mid_pt(cur_q[2], cur_q[3]);
								phase_q <= 2'd1;
							end
							2'd1: begin
								abc_q   <= cbf_mid_pt(ab_q, bc_q);
								bcd_q   <= cbf_mid_pt(bc_q, cd_q);
								phase_q <= 2'd2;
							end
							default: begin
								stk_c_q[IW'(sp_q)] <= '{cur_q[3], cd_q, bcd_q, abcd};
								stk_l_q[IW'(sp_q)] <= lvl_q - LW'(1);
								sp_q     <= sp_q + SPW'(1);
								cur_q[1] <= ab_q;
								cur_q[2] <= abc_q;
								cur_q[3] <= abcd;
								lvl_q    <= lvl_q - LW'(1);
								phase_q  <= 2'd0;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (go) begin
						if (idx_q == 2'd2) begin
							if (sp_q == '0) begin
								state_q <= ST_FINISH;
							end else begin
								cur_q   <= stk_c_q[top];
								lvl_q   <= stk_l_q[top];
								sp_q    <= sp_q - SPW'(1);
								phase_q <= '0;
								state_q <= ST_SPLIT;
							end
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				ST_FINISH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q    <= '{pend_q.point_x, pend_q.point_y,
							pend_q.box_min_x, pend_q.box_min_y,
							pend_q.box_max_x, pend_q.box_max_y, 1'b1};
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`AST_IMP(a_idle_no_pend, clk, arst_n, state_q == ST_IDLE, !pend_v_q)
	`AST_IMP(a_sp_bound, clk, arst_n, 1'b1, sp_q <= SPW'(STK))
	`AST_NXT(a_finish_last, clk, arst_n, state_q == ST_FINISH && pend_v_q && out_free, out_v_q && out_q.last_point)
	`AST_IMP(a_box_order, clk, arst_n, has_pt_q, min_x_q <= max_x_q && min_y_q <= max_y_q)

endmodule

`default_nettype wire

FILE: tb/cubic_bezier_flattener_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_tb
// Self-checking bench for the path command flattener: directed commands at the
// field extremes, depths 0..7, random paths under varying handshake idling and
// a long stall, every vertex checked by a predictor of subdivision, pen and box.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_flattener_tb
	import cbf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	logic [CBF_DEPTH_BITS-1:0] cfg_wdata;
	logic     in_valid;
	logic     in_ready;
	cbf_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	cbf_out_t out_data;

	// model state
	logic [CBF_DEPTH_BITS-1:0] pdepth;
	longint pen_x, pen_y, bmin_x, bmin_y, bmax_x, bmax_y;
	bit     need_subpath, has_point;
	cbf_out_t vertex_q[$];
	cbf_out_t cmd_vertices[$];

	int  errors;
	int  send_idle_pct, recv_idle_pct;
	int  hold_cycles;
	int  vertices_seen, cmds_sent;
	longint cycles;

	cubic_bezier_flattener u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint floor_half(longint a, longint b);
		longint s;
		s = a + b;
		return (s >= 0) ? s / 2 : -((-s + 1) / 2);
	endfunction

	function automatic longint weight_two_thirds(longint base, longint c);
		longint n;
		n = 2 * (c - base);
		return base + ((n >= 0) ? n / 3 : -((-n + 2) / 3));
	endfunction

	function automatic void add_vertex(longint x, longint y, bit force_it);
		cbf_out_t v;
		if (!force_it && has_point && x == pen_x && y == pen_y)
			return;
		pen_x = x;
		pen_y = y;
		has_point = 1;
		if (x < bmin_x) bmin_x = x;
		if (y < bmin_y) bmin_y = y;
		if (x > bmax_x) bmax_x = x;
		if (y > bmax_y) bmax_y = y;
		v.point_x = coord_t'(x);
		v.point_y = coord_t'(y);
		v.box_min_x = coord_t'(bmin_x);
		v.box_min_y = coord_t'(bmin_y);
		v.box_max_x = coord_t'(bmax_x);
		v.box_max_y = coord_t'(bmax_y);
		v.last_point = 1'b0;
		cmd_vertices = {cmd_vertices, v};
	endfunction

	function automatic void subdivide(longint p[8], int level);
		longint l[8], r[8];
		longint ab, bc, cd, abc, bcd, abcd;
		if (level <= 0) begin
			add_vertex(p[2], p[3], 0);
			add_vertex(p[4], p[5], 0);
			add_vertex(p[6], p[7], 0);
			return;
		end
		for (int k = 0; k < 2; k++) begin
			ab = floor_half(p[k], p[2+k]);
			bc = floor_half(p[2+k], p[4+k]);
			cd = floor_half(p[4+k], p[6+k]);
			abc = floor_half(ab, bc);
			bcd = floor_half(bc, cd);
			abcd = floor_half(abc, bcd);
			l[k] = p[k]; l[2+k] = ab; l[4+k] = abc; l[6+k] = abcd;
			r[k] = abcd; r[2+k] = bcd; r[4+k] = cd; r[6+k] = p[6+k];
		end
		subdivide(l, level - 1);
		subdivide(r, level - 1);
	endfunction

	function automatic void clear_path();
		pen_x = 0;
		pen_y = 0;
		bmin_x = CBF_COORD_MAX;
		bmin_y = CBF_COORD_MAX;
		bmax_x = CBF_COORD_MIN;
		bmax_y = CBF_COORD_MIN;
		need_subpath = 1;
		has_point = 0;
	endfunction

	function automatic void predict_vertices(cbf_in_t c);
		longint p[8];
		longint c1x, c1y, ex, ey;
		int d;
		c1x = c.ctrl1_x;
		c1y = c.ctrl1_y;
		ex = c.end_x;
		ey = c.end_y;
		d = (pdepth > CBF_MAX_DEPTH) ? CBF_MAX_DEPTH : int'(pdepth);
		cmd_vertices.delete();
		if (c.func == FUNC_RESET) begin
			clear_path();
			return;
		end
		if (c.func == FUNC_MOVE) begin
			add_vertex(ex, ey, 1);
			need_subpath = 0;
		end else begin
			if (need_subpath) begin
				add_vertex(c1x, c1y, 1);
				need_subpath = 0;
			end
			p[0] = pen_x;
			p[1] = pen_y;
			if (c.func == FUNC_CUBIC) begin
				p[2] = c1x;
				p[3] = c1y;
				p[4] = longint'(c.ctrl2_x);
				p[5] = longint'(c.ctrl2_y);
			end else begin
				p[2] = weight_two_thirds(pen_x, c1x);
				p[3] = weight_two_thirds(pen_y, c1y);
				p[4] = weight_two_thirds(ex, c1x);
				p[5] = weight_two_thirds(ey, c1y);
			end
			p[6] = ex;
			p[7] = ey;
			subdivide(p, d);
		end
		if (cmd_vertices.size() > 0)
			cmd_vertices[cmd_vertices.size()-1].last_point = 1'b1;
		vertex_q = {vertex_q, cmd_vertices};
	endfunction

	task automatic send_cmd(cbf_in_t c);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_vertices(c);
		cmds_sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (vertex_q.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_depth(int d);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_wdata <= CBF_DEPTH_BITS'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		pdepth = CBF_DEPTH_BITS'(d);
	endtask

	function automatic cbf_in_t make_cmd(logic [1:0] f, coord_t a, coord_t b, coord_t c2,
			coord_t d, coord_t e, coord_t g);
		cbf_in_t c;
		c.func = f;
		c.ctrl1_x = a; c.ctrl1_y = b;
		c.ctrl2_x = c2; c.ctrl2_y = d;
		c.end_x = e; c.end_y = g;
		return c;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 2047)) - 1024;
			2: return ($urandom_range(1)) ? CBF_COORD_MAX : CBF_COORD_MIN;
			default: return $signed($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	function automatic cbf_in_t rand_cmd();
		int m;
		logic [1:0] f;
		int r;
		m = $urandom_range(3);
		r = $urandom_range(99);
		f = (r < 45) ? FUNC_CUBIC : (r < 80) ? FUNC_QUAD : (r < 95) ? FUNC_MOVE : FUNC_RESET;
		return make_cmd(f, rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m),
			rand_coord(m), rand_coord(m));
	endfunction

	task automatic test_directed();
		send_cmd(make_cmd(FUNC_CUBIC, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(FUNC_CUBIC, CBF_COORD_MAX, CBF_COORD_MIN, CBF_COORD_MIN,
			CBF_COORD_MAX, CBF_COORD_MAX, CBF_COORD_MAX));
		send_cmd(make_cmd(FUNC_QUAD, CBF_COORD_MIN, CBF_COORD_MIN, 0, 0,
			CBF_COORD_MAX, CBF_COORD_MIN));
		send_cmd(make_cmd(FUNC_QUAD, CBF_COORD_MAX, CBF_COORD_MAX, -1, -1, -7, 5));
		send_cmd(make_cmd(FUNC_MOVE, 1, 2, 3, 4, -7, 5));
		send_cmd(make_cmd(FUNC_MOVE, 0, 0, 0, 0, -7, 5));
		send_cmd(make_cmd(FUNC_CUBIC, -7, 5, -7, 5, -7, 5));
		send_cmd(make_cmd(FUNC_RESET, -1, -1, -1, -1, -1, -1));
		send_cmd(make_cmd(FUNC_QUAD, 65536, -65536, 0, 0, -3, 3));
		send_cmd(make_cmd(FUNC_CUBIC, -1, -1, -1, -1, -1, -1));
		send_cmd(make_cmd(FUNC_RESET, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(FUNC_MOVE, 0, 0, 0, 0, CBF_COORD_MIN, CBF_COORD_MAX));
		send_cmd(make_cmd(FUNC_CUBIC, 1, 1, 2, 2, 3, 3));
	endtask

	task automatic test_depths();
		for (int d = 0; d < 8; d++) begin
			set_depth(d);
			repeat (3) send_cmd(rand_cmd());
			send_cmd(make_cmd(FUNC_QUAD, CBF_COORD_MIN, CBF_COORD_MAX, 0, 0,
				CBF_COORD_MAX, CBF_COORD_MIN));
		end
	endtask

	task automatic test_random(int n, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 39)
				set_depth($urandom_range(0, 4));
			send_cmd(rand_cmd());
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 400;
		repeat (6) send_cmd(rand_cmd());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cbf_out_t w;
		if (arst_n && out_valid && out_ready) begin
			vertices_seen++;
			if (vertex_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected vertex %h", $time, out_data);
			end else begin
				w = vertex_q.pop_front();
				if (w.point_x !== out_data.point_x)
					$display("%0t: point_x exp %h got %h", $time, w.point_x, out_data.point_x);
				if (w.point_y !== out_data.point_y)
					$display("%0t: point_y exp %h got %h", $time, w.point_y, out_data.point_y);
				if (w.box_min_x !== out_data.box_min_x)
					$display("%0t: box_min_x exp %h got %h", $time, w.box_min_x,
						out_data.box_min_x);
				if (w.box_min_y !== out_data.box_min_y)
					$display("%0t: box_min_y exp %h got %h", $time, w.box_min_y,
						out_data.box_min_y);
				if (w.box_max_x !== out_data.box_max_x)
					$display("%0t: box_max_x exp %h got %h", $time, w.box_max_x,
						out_data.box_max_x);
				if (w.box_max_y !== out_data.box_max_y)
					$display("%0t: box_max_y exp %h got %h", $time, w.box_max_y,
						out_data.box_max_y);
				if (w.last_point !== out_data.last_point)
					$display("%0t: last_point exp %b got %b", $time, w.last_point,
						out_data.last_point);
				if (w !== out_data)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		vertices_seen = 0;
		cmds_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pdepth = CBF_MAX_DEPTH;
		clear_path();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_depths();
		test_random(120, 20, 70);
		test_random(120, 70, 20);
		test_random(90, 0, 0);
		test_backpressure();
		set_depth(CBF_MAX_DEPTH);
		wait_drain();
		$display("covered %0d commands and %0d vertices over depths 0..7,", cmds_sent,
			vertices_seen);
		$display("including field extremes, resets, moves and a long output stall");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/cbf_pkg.sv
sv/cubic_bezier_flattener.sv
tb/cubic_bezier_flattener_tb.sv
